// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Port widths, command and character codes, micro-step encoding and the
// microcode table that steers the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int CMD_W     = 2;
	localparam int CHAR_W    = 8;
	localparam int IDX_W     = 11;
	localparam int COL_OUT_W = 7;
	localparam int ROW_OUT_W = 5;
	localparam int OFS_W     = 11;
	localparam int DATA_W    = 16;
	localparam int COLOR_W   = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd1;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		U_INIT, U_IDLE, U_PUT, U_SCR, U_SCRE, U_BLK, U_CLR, U_RD
	} tcw_step_t;

	typedef enum logic [1:0] {ADDR_KEEP, ADDR_CLR, ADDR_INC} tcw_addr_op_t;
	typedef enum logic [1:0] {WR_NONE, WR_ZERO, WR_BLANK, WR_CHAR} tcw_wr_sel_t;
	typedef enum logic [1:0] {RD_NONE, RD_COPY, RD_CELL} tcw_rd_sel_t;
	typedef enum logic [1:0] {CUR_KEEP, CUR_PUT, CUR_HOME} tcw_cur_op_t;
	typedef enum logic {LIM_CELLS, LIM_COPY} tcw_lim_t;
	typedef enum logic [1:0] {C_ALWAYS, C_NOT_LAST, C_SCROLL, C_DISPATCH} tcw_cond_t;

	typedef struct packed {
		logic         accept;
		tcw_addr_op_t addr_op;
		tcw_wr_sel_t  wr_sel;
		tcw_rd_sel_t  rd_sel;
		tcw_cur_op_t  cur_op;
		tcw_lim_t     lim;
		tcw_cond_t    cond;
		tcw_step_t    tgt_t;
		tcw_step_t    tgt_f;
		logic         finish;
	} tcw_uword_t;

	typedef struct packed {
		tcw_uword_t uw;
		logic       done;
	} tcw_ctl_t;

	typedef struct packed {
		logic             acc;
		logic [CMD_W-1:0] cmd;
		logic             last;
		logic             scroll;
	} tcw_stat_t;

	// microcode ROM
	function automatic tcw_uword_t tcw_ucode(tcw_step_t s);
		tcw_uword_t w;
		w = '0;
		unique case (s)
			U_INIT: begin
				w.wr_sel  = WR_ZERO;
				w.addr_op = ADDR_INC;
				w.lim     = LIM_CELLS;
				w.cond    = C_NOT_LAST;
				w.tgt_t   = U_INIT;
				w.tgt_f   = U_IDLE;
			end
			U_IDLE: begin
				w.accept  = 1'b1;
				w.addr_op = ADDR_CLR;
				w.cond    = C_DISPATCH;
				w.tgt_t   = U_IDLE;
				w.tgt_f   = U_IDLE;
			end
			U_PUT: begin
				w.cur_op = CUR_PUT;
				w.wr_sel = WR_CHAR;
				w.cond   = C_SCROLL;
				w.tgt_t  = U_SCR;
				w.tgt_f  = U_IDLE;
				w.finish = 1'b1;
			end
			U_SCR: begin
				w.rd_sel  = RD_COPY;
				w.addr_op = ADDR_INC;
				w.lim     = LIM_COPY;
				w.cond    = C_NOT_LAST;
				w.tgt_t   = U_SCR;
				w.tgt_f   = U_SCRE;
			end
			U_SCRE: begin
				// last copied word drains through the write port
				w.cond  = C_ALWAYS;
				w.tgt_t = U_BLK;
				w.tgt_f = U_BLK;
			end
			U_BLK: begin
				w.wr_sel  = WR_BLANK;
				w.addr_op = ADDR_INC;
				w.lim     = LIM_CELLS;
				w.cond    = C_NOT_LAST;
				w.tgt_t   = U_BLK;
				w.tgt_f   = U_IDLE;
				w.finish  = 1'b1;
			end
			U_CLR: begin
				w.wr_sel  = WR_BLANK;
				w.addr_op = ADDR_INC;
				w.cur_op  = CUR_HOME;
				w.lim     = LIM_CELLS;
				w.cond    = C_NOT_LAST;
				w.tgt_t   = U_CLR;
				w.tgt_f   = U_IDLE;
				w.finish  = 1'b1;
			end
			U_RD: begin
				w.rd_sel = RD_CELL;
				w.cond   = C_ALWAYS;
				w.tgt_t  = U_IDLE;
				w.tgt_f  = U_IDLE;
				w.finish = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/tcw_req_if.sv =====
// ----------------------------------------------------------------------------
// tcw_req_if: request channel
// One word carries a command, a character byte and a cell offset.
// ----------------------------------------------------------------------------
interface tcw_req_if;
	logic                         valid;
	logic                         ready;
	logic [tcw_pkg::CMD_W-1:0]    cmd;
	logic [tcw_pkg::CHAR_W-1:0]   char_code;
	logic [tcw_pkg::IDX_W-1:0]    cell_index;

	modport source (output valid, cmd, char_code, cell_index, input ready);
	modport sink   (input valid, cmd, char_code, cell_index, output ready);
endinterface

// ===== rtl/tcw_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tcw_rsp_if: response channel
// One word per request: cursor position, linear offset and read data.
// ----------------------------------------------------------------------------
interface tcw_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [tcw_pkg::COL_OUT_W-1:0]   cursor_col;
	logic [tcw_pkg::ROW_OUT_W-1:0]   cursor_row;
	logic [tcw_pkg::OFS_W-1:0]       cursor_offset;
	logic [tcw_pkg::DATA_W-1:0]      cell_data;

	modport source (output valid, cursor_col, cursor_row, cursor_offset, cell_data,
		input ready);
	modport sink   (input valid, cursor_col, cursor_row, cursor_offset, cell_data,
		output ready);
endinterface

// ===== rtl/tcw_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tcw_cfg_if: register write channel
// Register index and write data for the color registers.
// ----------------------------------------------------------------------------
interface tcw_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [tcw_pkg::CFG_IDX_W-1:0]   index;
	logic [tcw_pkg::COLOR_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram: generic single-write, single-read memory
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int W = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/tcw_useq.sv =====
// ----------------------------------------------------------------------------
// tcw_useq: microcode sequencer
// Step register, control word lookup and conditional next-step selection.
// ----------------------------------------------------------------------------
module tcw_useq (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_pkg::tcw_stat_t stat,
	output tcw_pkg::tcw_ctl_t  ctl
);

	tcw_pkg::tcw_step_t  step_q;
	tcw_pkg::tcw_step_t  nxt;
	tcw_pkg::tcw_uword_t uw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= tcw_pkg::U_INIT;
		end else begin
			step_q <= nxt;
		end
	end

	always_comb begin
		uw = tcw_pkg::tcw_ucode(step_q);
		unique case (uw.cond)
			tcw_pkg::C_ALWAYS:   nxt = uw.tgt_t;
			tcw_pkg::C_NOT_LAST: nxt = stat.last ? uw.tgt_f : uw.tgt_t;
			tcw_pkg::C_SCROLL:   nxt = stat.scroll ? uw.tgt_t : uw.tgt_f;
			tcw_pkg::C_DISPATCH: begin
				priority if (!stat.acc) begin
					nxt = uw.tgt_f;
				end else if (stat.cmd == tcw_pkg::CMD_PUT) begin
					nxt = tcw_pkg::U_PUT;
				end else if (stat.cmd == tcw_pkg::CMD_CLEAR) begin
					nxt = tcw_pkg::U_CLR;
				end else begin
					// read, and the unused code which reads back zero
					nxt = tcw_pkg::U_RD;
				end
			end
		endcase
		ctl.uw   = uw;
		ctl.done = uw.finish && (nxt == tcw_pkg::U_IDLE);
	end

	a_init_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == tcw_pkg::U_IDLE) |=> (step_q != tcw_pkg::U_INIT))
		else $error("sequencer returned to the clearing pass");

	a_dispatch_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == tcw_pkg::U_IDLE && nxt != tcw_pkg::U_IDLE) |-> stat.acc)
		else $error("left idle without an accepted word");

	a_scroll_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == tcw_pkg::U_SCRE) |=> (step_q == tcw_pkg::U_BLK))
		else $error("scroll did not blank the bottom row");

endmodule

// ===== rtl/tcw_dpath.sv =====
// ----------------------------------------------------------------------------
// tcw_dpath: console datapath
// Screen memory, address counter, cursor, color registers and result stage.
// ----------------------------------------------------------------------------
module tcw_dpath #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_pkg::tcw_ctl_t  ctl,
	output tcw_pkg::tcw_stat_t stat,
	tcw_req_if.sink            req,
	tcw_rsp_if.source          rsp,
	tcw_cfg_if.sink            cfg
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int TW    = $clog2(TAB_WIDTH);
	localparam int CXW   = $clog2(COLUMNS + TAB_WIDTH + 1);

	logic [tcw_pkg::COLOR_W-1:0]  fg_q, bg_q;
	logic [tcw_pkg::CMD_W-1:0]    cmd_q;
	logic [tcw_pkg::CHAR_W-1:0]   char_q;
	logic [tcw_pkg::IDX_W-1:0]    idx_q;
	logic                         rd_ok_q;
	logic [AW-1:0]                addr_q;
	logic                         cp_vld_s1;
	logic [AW-1:0]                cp_addr_s1;
	logic [CW-1:0]                col_q;
	logic [RW-1:0]                row_q;
	logic [AW-1:0]                base_q;
	logic [TW-1:0]                tph_q;
	logic                         res_pend_q;
	logic                         out_vld_q;
	logic [tcw_pkg::COL_OUT_W-1:0] ocol_q;
	logic [tcw_pkg::ROW_OUT_W-1:0] orow_q;
	logic [tcw_pkg::OFS_W-1:0]    oofs_q;
	logic [tcw_pkg::DATA_W-1:0]   odata_q;

	logic                         acc, out_free, emit, last;
	logic [AW-1:0]                lim_val;
	logic [7:0]                   attr;
	logic                         bs, prt, wrap, inc, scroll;
	logic [CXW-1:0]               col_x, col_a;
	logic [TW-1:0]                tph_a, tph_n;
	logic [CW-1:0]                col_n;
	logic                         we, re;
	logic [AW-1:0]                waddr, raddr;
	logic [tcw_pkg::DATA_W-1:0]   wdata, rdata;

	assign attr     = {bg_q, fg_q};
	assign out_free = !out_vld_q || rsp.ready;
	assign emit     = res_pend_q && out_free;
	assign req.ready = ctl.uw.accept && (!res_pend_q || out_free);
	assign acc      = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign lim_val = (ctl.uw.lim == tcw_pkg::LIM_COPY) ? AW'((ROWS - 1) * COLUMNS - 1)
		: AW'(CELLS - 1);
	assign last = (addr_q == lim_val);

	assign stat.acc    = acc;
	assign stat.cmd    = req.cmd;
	assign stat.last   = last;
	assign stat.scroll = scroll;

	// cursor step for one character
	always_comb begin
		col_x = CXW'(col_q);
		bs    = (char_q == tcw_pkg::CH_BS) && (col_q != '0);
		prt   = !char_q[7] && (char_q >= tcw_pkg::CH_SPACE);
		col_a = col_x;
		tph_a = tph_q;
		priority if (bs) begin
			col_a = col_x - CXW'(1);
			tph_a = (tph_q == '0) ? TW'(TAB_WIDTH - 1) : tph_q - TW'(1);
		end else if (char_q == tcw_pkg::CH_TAB) begin
			col_a = col_x + CXW'(TAB_WIDTH) - CXW'(tph_q);
			tph_a = '0;
		end else if (char_q == tcw_pkg::CH_CR || char_q == tcw_pkg::CH_LF) begin
			col_a = '0;
			tph_a = '0;
		end else if (prt) begin
			col_a = col_x + CXW'(1);
			tph_a = (tph_q == TW'(TAB_WIDTH - 1)) ? '0 : tph_q + TW'(1);
		end
		wrap   = (col_a >= CXW'(COLUMNS));
		col_n  = wrap ? '0 : CW'(col_a);
		tph_n  = wrap ? '0 : tph_a;
		inc    = wrap || (char_q == tcw_pkg::CH_LF);
		scroll = inc && (row_q == RW'(ROWS - 1));
	end

	// write port: a pending copy word has the port to itself
	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = '0;
		if (cp_vld_s1) begin
			we    = 1'b1;
			waddr = cp_addr_s1;
			wdata = rdata;
		end else begin
			unique case (ctl.uw.wr_sel)
				tcw_pkg::WR_NONE: we = 1'b0;
				tcw_pkg::WR_ZERO: we = 1'b1;
				tcw_pkg::WR_BLANK: begin
					we    = 1'b1;
					wdata = {attr, tcw_pkg::CH_SPACE};
				end
				tcw_pkg::WR_CHAR: begin
					we    = prt;
					waddr = base_q + AW'(col_q);
					wdata = {attr, char_q};
				end
			endcase
		end
	end

	assign re = (ctl.uw.rd_sel == tcw_pkg::RD_COPY)
		|| ((ctl.uw.rd_sel == tcw_pkg::RD_CELL) && rd_ok_q);
	assign raddr = (ctl.uw.rd_sel == tcw_pkg::RD_COPY) ? addr_q + AW'(COLUMNS)
		: AW'(idx_q);

	tcw_ram #(
		.W(tcw_pkg::DATA_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q       <= 4'd7;
			bg_q       <= 4'd0;
			addr_q     <= '0;
			cp_vld_s1  <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			base_q     <= '0;
			tph_q      <= '0;
			res_pend_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == tcw_pkg::CFG_BG) begin
					bg_q <= cfg.data;
				end else begin
					fg_q <= cfg.data;
				end
			end
			unique case (ctl.uw.addr_op)
				tcw_pkg::ADDR_KEEP: addr_q <= addr_q;
				tcw_pkg::ADDR_CLR:  addr_q <= '0;
				tcw_pkg::ADDR_INC:  addr_q <= addr_q + AW'(1);
			endcase
			cp_vld_s1 <= (ctl.uw.rd_sel == tcw_pkg::RD_COPY);
			unique case (ctl.uw.cur_op)
				tcw_pkg::CUR_KEEP: ;
				tcw_pkg::CUR_PUT: begin
					col_q <= col_n;
					tph_q <= tph_n;
					if (inc && !scroll) begin
						row_q  <= row_q + RW'(1);
						base_q <= base_q + AW'(COLUMNS);
					end
				end
				tcw_pkg::CUR_HOME: begin
					col_q  <= '0;
					tph_q  <= '0;
					row_q  <= '0;
					base_q <= '0;
				end
			endcase
			if (ctl.done) begin
				res_pend_q <= 1'b1;
			end else if (emit) begin
				res_pend_q <= 1'b0;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= addr_q;
		if (acc) begin
			cmd_q   <= req.cmd;
			char_q  <= req.char_code;
			idx_q   <= req.cell_index;
			rd_ok_q <= (32'(req.cell_index) < CELLS);
		end
		if (emit) begin
			ocol_q  <= tcw_pkg::COL_OUT_W'(col_q);
			orow_q  <= tcw_pkg::ROW_OUT_W'(row_q);
			oofs_q  <= tcw_pkg::OFS_W'(32'(base_q) + 32'(col_q));
			odata_q <= (cmd_q == tcw_pkg::CMD_READ && rd_ok_q) ? rdata : '0;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.cursor_col    = ocol_q;
	assign rsp.cursor_row    = orow_q;
	assign rsp.cursor_offset = oofs_q;
	assign rsp.cell_data     = odata_q;

	a_wr_port_free: assert property (@(posedge clk) disable iff (!arst_n)
		cp_vld_s1 |-> (ctl.uw.wr_sel == tcw_pkg::WR_NONE))
		else $error("copy write collides with a microcode write");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < COLUMNS) && (32'(row_q) < ROWS))
		else $error("cursor outside the screen");

	a_base_tracks_row: assert property (@(posedge clk) disable iff (!arst_n)
		32'(base_q) == 32'(row_q) * COLUMNS)
		else $error("row base out of step with row");

	a_done_pends: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.done |=> res_pend_q)
		else $error("finished word lost its result");

	a_acc_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !res_pend_q)
		else $error("word accepted over an unsent result");

endmodule

// ===== rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console
// Screen of 16-bit cells with cursor, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// req carries one word per command: put character, clear screen or read cell.
// rsp returns exactly one word per request: cursor column, row, linear offset
// (for the CRT cursor registers) and, for a read, the cell contents.
// cfg writes the foreground (index 0) and background (index 1) colors; write
// them only while no request is in flight.
// Steps, from acceptance until the result is loaded into the rsp register:
//   put character without scroll, read, unused command: U_PUT or U_RD.
//   put character that scrolls: U_PUT, then U_SCR moves rows up, set by the
//   single write port of the screen memory (one copy per cycle), U_SCRE drains
//   the last copy, U_BLK blanks the bottom row.
//   clear: U_CLR, one blank cell per cycle.
// Reset zeroes all COLUMNS*ROWS cells (2000 at default) with req.ready low; cfg
// writes are taken throughout. The cursor resets home, colors to 7 on 0.
// The rsp register lets the next request be accepted while a result waits;
// if rsp stalls, one further result is held back and req.ready drops.
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	parameter int TAB_WIDTH = 8
) (
	input logic        clk,
	input logic        arst_n,
	tcw_req_if.sink    req,
	tcw_rsp_if.source  rsp,
	tcw_cfg_if.sink    cfg
);

	tcw_pkg::tcw_ctl_t  ctl;
	tcw_pkg::tcw_stat_t stat;

	tcw_useq u_useq (
		.clk(clk),
		.arst_n(arst_n),
		.stat(stat),
		.ctl(ctl)
	);

	tcw_dpath #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.TAB_WIDTH(TAB_WIDTH)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.stat(stat),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the text console writer
// Drives put, clear, read and unused commands through the request channel,
// keeps its own copy of the screen, cursor and colors, and checks every
// response word field by field. Color registers change between phases, and
// the sender and the receiver idle at random to different degrees.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int TAB_WIDTH = 8;
	localparam int CELLS     = COLUMNS * ROWS;
	localparam int IDX_MAX   = (1 << tcw_pkg::IDX_W) - 1;

	localparam logic [tcw_pkg::CMD_W-1:0]  CMD_UNUSED = 2'd3;
	localparam logic [tcw_pkg::CHAR_W-1:0] PRINT_LAST = 8'h7F;

	localparam int PHASES     = 4;
	localparam int PHASE_WORDS = 113;

	typedef struct packed {
		logic [tcw_pkg::COL_OUT_W-1:0] col;
		logic [tcw_pkg::ROW_OUT_W-1:0] row;
		logic [tcw_pkg::OFS_W-1:0]     offset;
		logic [tcw_pkg::DATA_W-1:0]    data;
	} cursor_report_t;

	class console_scoreboard;
		logic [tcw_pkg::DATA_W-1:0]    screen [CELLS];
		logic [tcw_pkg::COL_OUT_W-1:0] cur_col;
		logic [tcw_pkg::ROW_OUT_W-1:0] cur_row;
		logic [tcw_pkg::COLOR_W-1:0]   fg;
		logic [tcw_pkg::COLOR_W-1:0]   bg;
		cursor_report_t                expected_reports [$];
		int                            mismatches;

		function new();
			foreach (screen[i])
				screen[i] = '0;
			cur_col    = '0;
			cur_row    = '0;
			fg         = 4'd7;
			bg         = 4'd0;
			mismatches = 0;
		endfunction

		function logic [tcw_pkg::DATA_W-1:0] attr_cell(logic [tcw_pkg::CHAR_W-1:0] ch);
			return {bg, fg, ch};
		endfunction

		function void set_color(logic [tcw_pkg::CFG_IDX_W-1:0] index,
			logic [tcw_pkg::COLOR_W-1:0] value);
			if (index == tcw_pkg::CFG_FG)
				fg = value;
			else
				bg = value;
		endfunction

		function void note_request(logic [tcw_pkg::CMD_W-1:0] cmd,
			logic [tcw_pkg::CHAR_W-1:0] ch, logic [tcw_pkg::IDX_W-1:0] idx);
			logic [tcw_pkg::DATA_W-1:0] data;
			int                         ofs;
			data = '0;
			case (cmd)
				tcw_pkg::CMD_PUT: begin
					if (ch == tcw_pkg::CH_BS) begin
						// backspace does nothing at the left edge
						if (cur_col != 0)
							cur_col = cur_col - 1'b1;
					end else if (ch == tcw_pkg::CH_TAB) begin
						cur_col = tcw_pkg::COL_OUT_W'((cur_col / TAB_WIDTH + 1) * TAB_WIDTH);
					end else if (ch == tcw_pkg::CH_CR) begin
						cur_col = '0;
					end else if (ch == tcw_pkg::CH_LF) begin
						cur_col = '0;
						cur_row = cur_row + 1'b1;
					end else if (ch >= tcw_pkg::CH_SPACE && ch <= PRINT_LAST) begin
						screen[cur_row * COLUMNS + cur_col] = attr_cell(ch);
						cur_col = cur_col + 1'b1;
					end
					if (cur_col >= COLUMNS) begin
						cur_col = '0;
						cur_row = cur_row + 1'b1;
					end
					// past the bottom row: scroll up, blank the last row
					if (cur_row >= ROWS) begin
						for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
							screen[i] = screen[i + COLUMNS];
						for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
							screen[i] = attr_cell(tcw_pkg::CH_SPACE);
						cur_row = tcw_pkg::ROW_OUT_W'(ROWS - 1);
					end
				end
				tcw_pkg::CMD_CLEAR: begin
					foreach (screen[i])
						screen[i] = attr_cell(tcw_pkg::CH_SPACE);
					cur_col = '0;
					cur_row = '0;
				end
				tcw_pkg::CMD_READ: begin
					if (idx < CELLS)
						data = screen[idx];
				end
				default: ;
			endcase
			ofs = cur_row * COLUMNS + cur_col;
			expected_reports.push_back('{cur_col, cur_row, ofs[tcw_pkg::OFS_W-1:0], data});
		endfunction

		function void check_response(logic [tcw_pkg::COL_OUT_W-1:0] col,
			logic [tcw_pkg::ROW_OUT_W-1:0] row, logic [tcw_pkg::OFS_W-1:0] offset,
			logic [tcw_pkg::DATA_W-1:0] data);
			cursor_report_t want;
			if (expected_reports.size() == 0) begin
				$error("response word with no request pending");
				mismatches++;
				return;
			end
			want = expected_reports.pop_front();
			if (col !== want.col) begin
				$error("cursor_col: expected %0d, got %0d", want.col, col);
				mismatches++;
			end
			if (row !== want.row) begin
				$error("cursor_row: expected %0d, got %0d", want.row, row);
				mismatches++;
			end
			if (offset !== want.offset) begin
				$error("cursor_offset: expected %0d, got %0d", want.offset, offset);
				mismatches++;
			end
			if (data !== want.data) begin
				$error("cell_data: expected %h, got %h", want.data, data);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tcw_req_if req ();
	tcw_rsp_if rsp ();
	tcw_cfg_if cfg ();

	text_console_writer #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.TAB_WIDTH(TAB_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	console_scoreboard board;
	int send_idle_pct;
	int recv_stall_pct;
	int rsp_hold_cycles;
	int counted_words;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off when requested
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_cycles > 0) begin
				rsp_hold_cycles--;
				rsp.ready = 1'b0;
			end else begin
				rsp.ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			board.check_response(rsp.cursor_col, rsp.cursor_row, rsp.cursor_offset,
				rsp.cell_data);
	end

	function automatic logic [tcw_pkg::CHAR_W-1:0] noise_byte();
		logic [tcw_pkg::CHAR_W-1:0] b;
		do
			b = tcw_pkg::CHAR_W'($urandom_range(0, 255));
		while (b == tcw_pkg::CH_BS || b == tcw_pkg::CH_TAB || b == tcw_pkg::CH_LF ||
			b == tcw_pkg::CH_CR || (b >= tcw_pkg::CH_SPACE && b <= PRINT_LAST));
		return b;
	endfunction

	task automatic send_word(input logic [tcw_pkg::CMD_W-1:0] cmd,
		input logic [tcw_pkg::CHAR_W-1:0] ch, input logic [tcw_pkg::IDX_W-1:0] idx);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
		req.valid      = 1'b1;
		req.cmd        = cmd;
		req.char_code  = ch;
		req.cell_index = idx;
		do
			@(posedge clk);
		while (!req.ready);
		board.note_request(cmd, ch, idx);
		// ignored bytes and the unused command do not count toward the total
		if (!(cmd == CMD_UNUSED || (cmd == tcw_pkg::CMD_PUT && ch != tcw_pkg::CH_BS &&
			ch != tcw_pkg::CH_TAB && ch != tcw_pkg::CH_LF && ch != tcw_pkg::CH_CR &&
			(ch < tcw_pkg::CH_SPACE || ch > PRINT_LAST))))
			counted_words++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req.valid = 1'b0;
		while (board.expected_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_color(input logic [tcw_pkg::CFG_IDX_W-1:0] index,
		input logic [tcw_pkg::COLOR_W-1:0] value);
		@(negedge clk);
		cfg.valid = 1'b1;
		cfg.index = index;
		cfg.data  = value;
		do
			@(posedge clk);
		while (!cfg.ready);
		board.set_color(index, value);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic run_burst();
		int                         kind;
		int                         n;
		int                         r;
		int                         ofs;
		logic [tcw_pkg::CHAR_W-1:0] b;
		kind = $urandom_range(99);
		if (kind < 45) begin
			// a line of text, now and then long enough to wrap
			n = ($urandom_range(99) < 15) ? $urandom_range(60, 170) : $urandom_range(0, 20);
			for (int k = 0; k < n; k++) begin
				r = $urandom_range(99);
				if (r < 84)
					b = tcw_pkg::CHAR_W'($urandom_range(tcw_pkg::CH_SPACE, PRINT_LAST));
				else if (r < 90)
					b = tcw_pkg::CH_TAB;
				else if (r < 95)
					b = tcw_pkg::CH_BS;
				else if (r < 97)
					b = tcw_pkg::CH_CR;
				else
					b = noise_byte();
				send_word(tcw_pkg::CMD_PUT, b, tcw_pkg::IDX_W'($urandom_range(0, IDX_MAX)));
			end
			if ($urandom_range(99) < 85)
				send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_LF,
					tcw_pkg::IDX_W'($urandom_range(0, IDX_MAX)));
		end else if (kind < 65) begin
			n = $urandom_range(1, 6);
			for (int k = 0; k < n; k++) begin
				r = $urandom_range(99);
				if (r < 50) begin
					// just behind the cursor, where text was last written
					ofs = board.cur_row * COLUMNS + board.cur_col - $urandom_range(1, 4);
					if (ofs < 0)
						ofs = 0;
				end else if (r < 80) begin
					ofs = $urandom_range(0, CELLS - 1);
				end else if (r < 90) begin
					ofs = $urandom_range(CELLS, IDX_MAX);
				end else begin
					ofs = $urandom_range(1) ? CELLS - 1 : 0;
				end
				send_word(tcw_pkg::CMD_READ, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
					ofs[tcw_pkg::IDX_W-1:0]);
			end
		end else if (kind < 68) begin
			send_word(tcw_pkg::CMD_CLEAR, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
				tcw_pkg::IDX_W'($urandom_range(0, IDX_MAX)));
		end else if (kind < 80) begin
			n = $urandom_range(1, 4);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(99) < 30)
					send_word(CMD_UNUSED, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
						tcw_pkg::IDX_W'($urandom_range(0, IDX_MAX)));
				else
					send_word(tcw_pkg::CMD_PUT, noise_byte(),
						tcw_pkg::IDX_W'($urandom_range(0, IDX_MAX)));
			end
		end else begin
			// runs of newlines push the cursor to the bottom and scroll
			n = $urandom_range(1, 12);
			for (int k = 0; k < n; k++)
				send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_LF,
					tcw_pkg::IDX_W'($urandom_range(0, IDX_MAX)));
		end
	endtask

	initial begin
		bit drained_mid;
		board           = new();
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		rsp_hold_cycles = 0;
		counted_words   = 0;
		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.cmd         = tcw_pkg::CMD_PUT;
		req.char_code   = '0;
		req.cell_index  = '0;
		cfg.valid       = 1'b0;
		cfg.index       = tcw_pkg::CFG_FG;
		cfg.data        = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset colors, printable edges, ignored bytes, cursor controls
		send_word(tcw_pkg::CMD_READ, 8'hFF, '0);
		send_word(tcw_pkg::CMD_PUT, 8'h41, 11'h7FF);
		send_word(tcw_pkg::CMD_PUT, PRINT_LAST, '0);
		send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_SPACE, '0);
		send_word(tcw_pkg::CMD_PUT, 8'h1F, '0);
		send_word(tcw_pkg::CMD_PUT, 8'h80, '0);
		send_word(tcw_pkg::CMD_PUT, 8'hFF, '0);
		send_word(tcw_pkg::CMD_PUT, 8'h00, '0);
		send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, '0);
		send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_CR, '0);
		send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, '0);   // at column zero: no move
		send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_TAB, '0);
		send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_TAB, '0);
		send_word(tcw_pkg::CMD_READ, '0, 11'd1);
		send_word(tcw_pkg::CMD_READ, '0, 11'd2);
		send_word(tcw_pkg::CMD_READ, '0, tcw_pkg::IDX_W'(CELLS - 1));
		send_word(tcw_pkg::CMD_READ, '0, tcw_pkg::IDX_W'(CELLS));  // past the screen reads zero
		send_word(tcw_pkg::CMD_READ, '0, 11'h7FF);
		send_word(CMD_UNUSED, 8'hFF, 11'h7FF);
		send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_LF, '0);
		send_word(tcw_pkg::CMD_CLEAR, '0, '0);
		send_word(tcw_pkg::CMD_READ, '0, '0);
		wait_drained();

		counted_words = 0;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					write_color(tcw_pkg::CFG_FG, 4'hF);
					write_color(tcw_pkg::CFG_BG, 4'h0);
					// long receiver hold-off so the input backs up
					rsp_hold_cycles = 400;
				end
				1: begin
					send_idle_pct  = 68;
					recv_stall_pct = 0;
					write_color(tcw_pkg::CFG_FG, 4'h0);
					write_color(tcw_pkg::CFG_BG, 4'hF);
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 68;
					write_color(tcw_pkg::CFG_FG, tcw_pkg::COLOR_W'($urandom_range(0, 15)));
					write_color(tcw_pkg::CFG_BG, tcw_pkg::COLOR_W'($urandom_range(0, 15)));
				end
				default: begin
					send_idle_pct  = 6;
					recv_stall_pct = 6;
					write_color(tcw_pkg::CFG_FG, 4'hF);
					write_color(tcw_pkg::CFG_BG, 4'hF);
				end
			endcase
			drained_mid = 1'b0;
			while (counted_words < (phase + 1) * PHASE_WORDS) begin
				run_burst();
				if (phase == 2 && !drained_mid &&
					counted_words >= phase * PHASE_WORDS + PHASE_WORDS / 2) begin
					wait_drained();
					drained_mid = 1'b1;
				end
			end
			wait_drained();
		end

		repeat (30) @(posedge clk);
		if (board.mismatches == 0 && board.expected_reports.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
